@@ rtl/point_in_hexahedron_test_macros.svh @@
// Assertion macros shared by the point-in-hexahedron blocks.
// No dependencies.
`ifndef POINT_IN_HEXAHEDRON_TEST_MACROS_SVH
`define POINT_IN_HEXAHEDRON_TEST_MACROS_SVH

// Checks an implication on the next cycle after the condition.
`define PIH_ASSERT_NEXT(label, clk, rst_n, cond, expect_n) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_n)) \
        else $error("assertion failed");

// Checks an implication in the same cycle.
`define PIH_ASSERT_NOW(label, clk, rst_n, cond, expect_n) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_n)) \
        else $error("assertion failed");

`endif

@@ rtl/pih_pkg.sv @@
// Shared constants, types and the slot permutation for the hexahedron test.
// No dependencies.
package pih_pkg;
    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int NRM_BITS = 2 * DIFF_BITS + 1;
    localparam int ACC_BITS = NRM_BITS + COORD_BITS + 3;
    localparam int NUM_PLANES = 24;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Datapath operations.
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_NRM = 3'd2;
    localparam logic [2:0] OP_HGT = 3'd3;
    localparam logic [2:0] OP_QRY = 3'd4;
    localparam logic [2:0] OP_DONE = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] plane;
        logic [1:0] comp;
        logic       first;
    } pih_cmd_t;

    typedef struct packed {
        logic hit;
    } pih_sts_t;

    // User corner number to internal slot (inverse of slot-source list).
    function automatic logic [2:0] user_to_slot(input logic [2:0] user);
        logic [2:0] s;
        unique case (user)
            3'd0: s = 3'd6;
            3'd1: s = 3'd0;
            3'd2: s = 3'd2;
            3'd3: s = 3'd1;
            3'd4: s = 3'd4;
            3'd5: s = 3'd5;
            3'd6: s = 3'd3;
            default: s = 3'd7;
        endcase
        return s;
    endfunction

    // Corner slots (a,b,c) of a plane, packed a,b,c.
    function automatic logic [8:0] plane_corners(input logic [4:0] pl);
        logic [2:0] t;
        logic [2:0] l;
        logic [8:0] r;
        t = pl[4:2];
        l = (t == 3'd0) ? 3'd5 : t - 3'd1;
        unique case (pl[1:0])
            2'd0: r = {3'd7, t, l};
            2'd1: r = {3'd6, 3'd7, l};
            2'd2: r = {3'd6, l, t};
            default: r = {3'd6, t, 3'd7};
        endcase
        return r;
    endfunction
endpackage

@@ rtl/pih_datapath.sv @@
// Datapath: corner store, plane table, shared normal multipliers and a multiply-accumulate unit.
// Depends on pih_pkg and the macros header.
`include "point_in_hexahedron_test_macros.svh"
module pih_datapath
    import pih_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pih_cmd_t               cmd,
    input  logic [2:0]             corner_number,
    input  logic [15:0]            coord_x,
    input  logic [15:0]            coord_y,
    input  logic [15:0]            coord_z,
    output pih_sts_t               sts
);
    logic signed [COORD_BITS-1:0] cx_reg [8];
    logic signed [COORD_BITS-1:0] cy_reg [8];
    logic signed [COORD_BITS-1:0] cz_reg [8];
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic signed [NRM_BITS-1:0]   nx_reg [NUM_PLANES];
    logic signed [NRM_BITS-1:0]   ny_reg [NUM_PLANES];
    logic signed [NRM_BITS-1:0]   nz_reg [NUM_PLANES];
    logic signed [ACC_BITS-1:0]   h_reg [NUM_PLANES];
    logic signed [ACC_BITS-1:0]   acc_reg, acc_next;
    logic signed [ACC_BITS-1:0]   prod_reg;
    logic                         inside_reg, tet_ok_reg;
    logic                         res_reg;

    logic [8:0] abc;
    logic [2:0] sa, sb, sc;
    logic signed [DIFF_BITS-1:0] ux, uy, uz, wx, wy, wz, m0a, m0b, m1a, m1b;
    logic signed [NRM_BITS-1:0] m_a, m_b, prod_n;
    logic signed [NRM_BITS-1:0] opn;
    logic signed [COORD_BITS-1:0] opc;
    logic signed [ACC_BITS-1:0] prod_h;
    logic [2:0] slot;

    assign abc = plane_corners(cmd.plane);
    assign sa = abc[8:6];
    assign sb = abc[5:3];
    assign sc = abc[2:0];
    assign slot = user_to_slot(corner_number);

    always_comb
    begin
        ux = DIFF_BITS'(cx_reg[sa]) - DIFF_BITS'(cx_reg[sc]);
        uy = DIFF_BITS'(cy_reg[sa]) - DIFF_BITS'(cy_reg[sc]);
        uz = DIFF_BITS'(cz_reg[sa]) - DIFF_BITS'(cz_reg[sc]);
        wx = DIFF_BITS'(cx_reg[sb]) - DIFF_BITS'(cx_reg[sa]);
        wy = DIFF_BITS'(cy_reg[sb]) - DIFF_BITS'(cy_reg[sa]);
        wz = DIFF_BITS'(cz_reg[sb]) - DIFF_BITS'(cz_reg[sa]);
        // One normal component is u_i*w_j - u_j*w_i; comp selects which.
        unique case (cmd.comp)
            2'd0: begin m0a = uy; m0b = wz; m1a = uz; m1b = wy; end
            2'd1: begin m0a = uz; m0b = wx; m1a = ux; m1b = wz; end
            default: begin m0a = ux; m0b = wy; m1a = uy; m1b = wx; end
        endcase
        m_a = NRM_BITS'(m0a) * NRM_BITS'(m0b);
        m_b = NRM_BITS'(m1a) * NRM_BITS'(m1b);
        prod_n = m_a - m_b;
        // Dot product term: normal component times point or corner a.
        unique case (cmd.comp)
            2'd0: opn = nx_reg[cmd.plane];
            2'd1: opn = ny_reg[cmd.plane];
            default: opn = nz_reg[cmd.plane];
        endcase
        if (cmd.op == OP_HGT)
        begin
            unique case (cmd.comp)
                2'd0: opc = cx_reg[sa];
                2'd1: opc = cy_reg[sa];
                default: opc = cz_reg[sa];
            endcase
        end
        else
        begin
            unique case (cmd.comp)
                2'd0: opc = px_reg;
                2'd1: opc = py_reg;
                default: opc = pz_reg;
            endcase
        end
        prod_h = ACC_BITS'(opn) * ACC_BITS'(opc);
        acc_next = (cmd.first ? '0 : acc_reg) + prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                cx_reg[i] <= '0;
                cy_reg[i] <= '0;
                cz_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                nx_reg[i] <= '0;
                ny_reg[i] <= '0;
                nz_reg[i] <= '0;
                h_reg[i] <= '0;
            end
            px_reg <= '0;
            py_reg <= '0;
            pz_reg <= '0;
            acc_reg <= '0;
            prod_reg <= '0;
            inside_reg <= 1'b0;
            tet_ok_reg <= 1'b1;
            res_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    if (cmd.first)
                    begin
                        px_reg <= coord_x[COORD_BITS-1:0];
                        py_reg <= coord_y[COORD_BITS-1:0];
                        pz_reg <= coord_z[COORD_BITS-1:0];
                        inside_reg <= 1'b0;
                        tet_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        cx_reg[slot] <= coord_x[COORD_BITS-1:0];
                        cy_reg[slot] <= coord_y[COORD_BITS-1:0];
                        cz_reg[slot] <= coord_z[COORD_BITS-1:0];
                    end
                end
                OP_NRM:
                begin
                    unique case (cmd.comp)
                        2'd0: nx_reg[cmd.plane] <= prod_n;
                        2'd1: ny_reg[cmd.plane] <= prod_n;
                        default: nz_reg[cmd.plane] <= prod_n;
                    endcase
                end
                OP_HGT:
                begin
                    prod_reg <= prod_h;
                    acc_reg <= acc_next;
                    if (cmd.comp == 2'd3)
                        h_reg[cmd.plane] <= acc_next;
                end
                OP_QRY:
                begin
                    prod_reg <= prod_h;
                    acc_reg <= acc_next;
                    if (cmd.comp == 2'd3)
                    begin
                        // Plane 0 of each tetrahedron is strict.
                        logic pass;
                        pass = (cmd.plane[1:0] == 2'd0) ? (acc_next > h_reg[cmd.plane])
                                                       : (acc_next >= h_reg[cmd.plane]);
                        if (cmd.plane[1:0] == 2'd3)
                        begin
                            if (tet_ok_reg && pass)
                                inside_reg <= 1'b1;
                            tet_ok_reg <= 1'b1;
                        end
                        else
                            tet_ok_reg <= tet_ok_reg && pass;
                    end
                end
                OP_DONE: res_reg <= inside_reg;
                default: ;
            endcase
        end
    end

    assign sts.hit = res_reg;

    `PIH_ASSERT_NEXT(a_qry_clear, clk, rst_n, cmd.op == OP_LOAD && cmd.first, !inside_reg)
    `PIH_ASSERT_NOW(a_op_range, clk, rst_n, cmd.op != OP_NONE, cmd.op <= OP_DONE)
    `PIH_ASSERT_NOW(a_comp_nrm, clk, rst_n, cmd.op == OP_NRM, cmd.comp != 2'd3)
endmodule

@@ rtl/pih_ctrl.sv @@
// Sequencer: load, plane rebuild and query walk over the 24 planes.
// Depends on pih_pkg and the macros header.
`include "point_in_hexahedron_test_macros.svh"
module pih_ctrl
    import pih_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic     mode,
    output logic     out_valid,
    input  logic     out_stall,
    output pih_cmd_t cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUILD = 2'd1;
    localparam logic [1:0] ST_QUERY = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [4:0] plane_reg, plane_next;
    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    // Build: comp 0..2 normals, then height steps (prime, 3 products + drain, then a spare step).
    // Query: 4 steps per plane; step 0 primes, 1..3 accumulate.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        plane_next = plane_reg;
        step_next = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd = '{op: OP_NONE, plane: plane_reg, comp: 2'd0, first: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.op = OP_LOAD;
                    cmd.first = (mode == MODE_QUERY);
                    plane_next = '0;
                    step_next = '0;
                    state_next = (mode == MODE_QUERY) ? ST_QUERY : ST_BUILD;
                end
            end
            ST_BUILD:
            begin
                if (step_reg < 3'd3)
                begin
                    cmd.op = OP_NRM;
                    cmd.comp = step_reg[1:0];
                end
                else
                begin
                    cmd.op = OP_HGT;
                    cmd.comp = 2'(step_reg - 3'd3);
                    cmd.first = (step_reg == 3'd4);
                end
                if (step_reg == 3'd7)
                begin
                    step_next = '0;
                    plane_next = plane_reg + 5'd1;
                    if (plane_reg == 5'(NUM_PLANES - 1))
                        state_next = ST_IDLE;
                end
                else
                    step_next = step_reg + 3'd1;
            end
            ST_QUERY:
            begin
                cmd.op = OP_QRY;
                cmd.comp = step_reg[1:0];
                cmd.first = (step_reg == 3'd1);
                if (step_reg == 3'd4)
                begin
                    // The answer waits here until the output register is free.
                    cmd.op = OP_NONE;
                    if (!out_valid_reg || !out_stall)
                    begin
                        cmd.op = OP_DONE;
                        state_next = ST_IDLE;
                        out_valid_next = 1'b1;
                    end
                end
                else if (step_reg == 3'd3)
                begin
                    step_next = '0;
                    plane_next = plane_reg + 5'd1;
                    if (plane_reg == 5'(NUM_PLANES - 1))
                    begin
                        step_next = 3'd4;
                        plane_next = plane_reg;
                    end
                end
                else
                    step_next = step_reg + 3'd1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            plane_reg <= '0;
            step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            plane_reg <= plane_next;
            step_reg <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `PIH_ASSERT_NOW(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `PIH_ASSERT_NOW(a_plane_range, clk, rst_n, state_reg != ST_IDLE, plane_reg < 5'(NUM_PLANES))
    `PIH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && out_stall, out_valid_reg)
endmodule

@@ rtl/point_in_hexahedron_test.sv @@
// Point-in-hexahedron test: a corner load stores the corner and rebuilds all 24
// planes with shared multipliers, and the input stalls until the rebuild is done.
// A query walks the 24 planes with the same multiply-accumulate unit; its answer
// is presented once the walk ends and the output register is free, and the next
// word can be taken in the cycle in which the answer is presented. An answer waits
// in its own output register, so a stalled answer does not block the next word;
// only a second finished query waits until that register is free.
// Depends on pih_pkg, pih_ctrl and pih_datapath.
module point_in_hexahedron_test
    import pih_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [2:0]  corner_number,
    input  logic [15:0] coord_x,
    input  logic [15:0] coord_y,
    input  logic [15:0] coord_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        inside_res
);
    pih_cmd_t cmd;
    pih_sts_t sts;

    pih_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
    );

    pih_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .corner_number(corner_number),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .sts(sts)
    );

    assign inside_res = sts.hit;
endmodule

@@ tb/sv/point_in_hexahedron_test_tb.sv @@
// Self-checking testbench for the point-in-hexahedron test block.
// Depends on pih_pkg and point_in_hexahedron_test; predicts each query answer from corners.
`timescale 1ns / 1ps

module point_in_hexahedron_test_tb;
    import pih_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [2:0]  corner_number;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [15:0] coord_z;
    logic        out_valid;
    logic        out_stall;
    logic        inside_res;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int EXP_DEPTH = 4096;

    longint corners[8][3];
    logic   exp_mem [EXP_DEPTH];
    int     exp_wr;
    int     exp_rd;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     idle_cycles;
    bit     failed;

    point_in_hexahedron_test dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .corner_number(corner_number), .coord_x(coord_x),
        .coord_y(coord_y), .coord_z(coord_z), .out_valid(out_valid),
        .out_stall(out_stall), .inside_res(inside_res)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [2:0] slot_of(input logic [2:0] user);
        logic [2:0] perm [8];
        logic [2:0] s;
        perm = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5, 3'd0, 3'd7};
        s = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (perm[i] == user)
                s = i[2:0];
        end
        return s;
    endfunction

    // Signed test of point p against the plane through corners a, b, c.
    function automatic longint plane_margin(input int a, input int b, input int c,
                                            input longint p[3]);
        longint u[3];
        longint w[3];
        longint n[3];
        for (int k = 0; k < 3; k++)
        begin
            u[k] = corners[a][k] - corners[c][k];
            w[k] = corners[b][k] - corners[a][k];
        end
        n[0] = u[1] * w[2] - u[2] * w[1];
        n[1] = u[2] * w[0] - u[0] * w[2];
        n[2] = u[0] * w[1] - u[1] * w[0];
        return (p[0] - corners[a][0]) * n[0] + (p[1] - corners[a][1]) * n[1]
             + (p[2] - corners[a][2]) * n[2];
    endfunction

    function automatic logic point_inside(input longint p[3]);
        int l;
        for (int t = 0; t < 6; t++)
        begin
            l = (t == 0) ? 5 : t - 1;
            if (plane_margin(7, t, l, p) > 0 && plane_margin(6, 7, l, p) >= 0
                && plane_margin(6, l, t, p) >= 0 && plane_margin(6, t, 7, p) >= 0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_word(input logic m, input logic [2:0] cn,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
        longint p[3];
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        corner_number <= cn;
        coord_x       <= x;
        coord_y       <= y;
        coord_z       <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p[0] = longint'(signed'(x));
        p[1] = longint'(signed'(y));
        p[2] = longint'(signed'(z));
        if (m == MODE_LOAD)
        begin
            for (int k = 0; k < 3; k++)
                corners[slot_of(cn)][k] = p[k];
        end
        else
        begin
            exp_mem[exp_wr % EXP_DEPTH] = point_inside(p);
            exp_wr = exp_wr + 1;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (exp_rd != exp_wr)
            @(posedge clk);
        // A load gives no answer, so let a full plane rebuild finish.
        repeat (400) @(posedge clk);
    endtask

    task automatic load_cube(input int lo, input int hi);
        for (int u = 0; u < 8; u++)
            send_word(MODE_LOAD, u[2:0], (u & 1) ? hi[15:0] : lo[15:0],
                      (u & 2) ? hi[15:0] : lo[15:0], (u & 4) ? hi[15:0] : lo[15:0]);
    endtask

    task automatic test_reset_state();
        send_word(MODE_QUERY, 3'd0, 16'd0, 16'd0, 16'd0);
        send_word(MODE_QUERY, 3'd7, 16'h7fff, 16'h8000, 16'hffff);
    endtask

    task automatic test_directed();
        load_cube(-100, 100);
        send_word(MODE_QUERY, 3'd0, 16'd0, 16'd0, 16'd0);
        send_word(MODE_QUERY, 3'd5, 16'd100, 16'd0, 16'd0);
        send_word(MODE_QUERY, 3'd2, 16'd101, 16'd0, 16'd0);
        send_word(MODE_QUERY, 3'd0, 16'd100, 16'd100, 16'd100);
        send_word(MODE_QUERY, 3'd0, -16'sd100, -16'sd100, -16'sd100);
        send_word(MODE_QUERY, 3'd0, 16'd50, 16'd50, 16'd50);
        load_cube(-32768, 32767);
        send_word(MODE_QUERY, 3'd0, 16'h7fff, 16'h7fff, 16'h7fff);
        send_word(MODE_QUERY, 3'd0, 16'h8000, 16'h8000, 16'h8000);
        send_word(MODE_QUERY, 3'd0, 16'h0001, 16'hfffe, 16'h1234);
    endtask

    // Mostly a full corner set with jitter, then queries near it.
    task automatic test_random(input int words);
        int sent;
        int span;
        int c;
        sent = 0;
        while (sent < words)
        begin
            span = ($urandom_range(3) == 0) ? 32000 : $urandom_range(2000, 10);
            c = $urandom_range(15000) - 7500;
            for (int u = 0; u < 8; u++)
                send_word(MODE_LOAD, u[2:0],
                          16'(c + ((u & 1) ? span : -span) + $urandom_range(span / 4)),
                          16'(c + ((u & 2) ? span : -span) - $urandom_range(span / 4)),
                          16'(c + ((u & 4) ? span : -span) + $urandom_range(span / 4)));
            for (int q = 0; q < 20; q++)
            begin
                if ($urandom_range(9) == 0)
                    send_word(MODE_QUERY, 3'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
                else if ($urandom_range(9) == 0)
                    send_word(MODE_LOAD, 3'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
                else
                    send_word(MODE_QUERY, 3'($urandom),
                              16'(c + $urandom_range(3 * span) - 3 * span / 2),
                              16'(c + $urandom_range(3 * span) - 3 * span / 2),
                              16'(c + $urandom_range(3 * span) - 3 * span / 2));
            end
            sent += 28;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (out_valid && !out_stall)
            begin
                if (exp_rd == exp_wr)
                begin
                    $display("%0t: answer %0b with none expected", $time, inside_res);
                    failed = 1'b1;
                end
                else
                begin
                    if (exp_mem[exp_rd % EXP_DEPTH] !== inside_res)
                    begin
                        $display("%0t: inside_res expected %0b actual %0b", $time,
                                 exp_mem[exp_rd % EXP_DEPTH], inside_res);
                        failed = 1'b1;
                    end
                    exp_rd = exp_rd + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_LOAD;
        corner_number  = 3'd0;
        coord_x        = 16'd0;
        coord_y        = 16'd0;
        coord_z        = 16'd0;
        out_stall      = 1'b0;
        failed         = 1'b0;
        idle_cycles    = 0;
        exp_wr         = 0;
        exp_rd         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int s = 0; s < 8; s++)
            for (int k = 0; k < 3; k++)
                corners[s][k] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed();
        test_random(560);
        send_idle_pct = 84;
        test_random(420);
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        test_random(420);
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        test_random(420);
        drain();
        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pih_pkg.sv
rtl/pih_datapath.sv
rtl/pih_ctrl.sv
rtl/point_in_hexahedron_test.sv
tb/sv/point_in_hexahedron_test_tb.sv
